// ===== hdl/binary_modular_inverse_defines.svh =====
// Assertion macros for the modular inverse block.
// Both expect clk and rst_n in the scope where they are used.
`ifndef BINARY_MODULAR_INVERSE_DEFINES_SVH
`define BINARY_MODULAR_INVERSE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define BMI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular inverse assertion failed");

// Next-cycle implication
`define BMI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular inverse assertion failed");

`else

`define BMI_ASSERT_IMP(lbl, ante, cons)
`define BMI_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/bmi_pkg.sv =====
package bmi_pkg;

    // Width of the payload fields on the ports
    localparam int FIELD_W   = 64;
    // Default working width
    localparam int DEF_WIDTH = 64;

    // Shared arithmetic unit operations
    typedef logic [1:0] op_t;
    localparam op_t OP_ADD   = 2'd0;  // plain add
    localparam op_t OP_SUB   = 2'd1;  // plain subtract
    localparam op_t OP_ADDM  = 2'd2;  // add modulo m, operands below m
    localparam op_t OP_HALFM = 2'd3;  // halve modulo m, m odd

endpackage

// ===== hdl/bmi_if.sv =====
// Request channel: value and modulus
interface bmi_req_if;
    logic                         valid;
    logic                         ready;
    logic [bmi_pkg::FIELD_W-1:0]  value;
    logic [bmi_pkg::FIELD_W-1:0]  modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

// Response channel: inverse and failure flag
interface bmi_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bmi_pkg::FIELD_W-1:0]  inverse;
    logic                         no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

// ===== hdl/bmi_alu.sv =====
// Shared arithmetic unit: add, subtract, modular add and modular halve.
module bmi_alu #(
    parameter int WIDTH = bmi_pkg::DEF_WIDTH
) (
    input  bmi_pkg::op_t     op,
    input  logic [WIDTH:0]   opa,
    input  logic [WIDTH:0]   opb,
    input  logic [WIDTH-1:0] m,
    output logic [WIDTH:0]   res
);
    import bmi_pkg::*;

    logic [WIDTH+1:0] sum_w;
    logic [WIDTH+1:0] red_w;
    logic [WIDTH:0]   half_w;

    always_comb
    begin
        sum_w  = {1'b0, opa} + {1'b0, opb};
        // reduce once: operands are below m, so the sum is below 2m
        red_w  = sum_w - {2'b00, m};
        // odd p: (p >> 1) + (m >> 1) + 1 is (p + m) / 2
        half_w = {1'b0, opa[WIDTH:1]} + {2'b00, m[WIDTH-1:1]}
                 + {{WIDTH{1'b0}}, 1'b1};
        case (op)
            OP_ADD:   res = sum_w[WIDTH:0];
            OP_SUB:   res = opa - opb;
            OP_ADDM:  res = red_w[WIDTH+1] ? sum_w[WIDTH:0] : red_w[WIDTH:0];
            OP_HALFM: res = opa[0] ? half_w : {1'b0, opa[WIDTH:1]};
            default:  res = sum_w[WIDTH:0];
        endcase
    end

endmodule

// ===== hdl/binary_modular_inverse.sv =====
// Channel  Dir  Fields                 Notes
// req      in   value, modulus         taken only while the sequencer is idle
// rsp      out  inverse, no_inverse    one beat per request, held until taken
//
// Steps: load, make u odd, then per subtraction pass a subtract and an
// accumulate plus one halving step per halving, then hand off; small operands
// finish sooner than full-width ones. All steps share the ALU in bmi_alu.
// Passes are capped at 2*WIDTH+4, then no_inverse is set.
// Modulus one or even finishes right after the load.
// Reset (rst_n low, async) returns the sequencer to idle and drops rsp.valid.
// A new request is taken while the previous result still waits on rsp.
`include "binary_modular_inverse_defines.svh"

module binary_modular_inverse #(
    parameter int WIDTH = bmi_pkg::DEF_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    bmi_req_if.sink       req,
    bmi_rsp_if.source     rsp
);
    import bmi_pkg::*;

    localparam int PASS_CAP = 2 * WIDTH + 4;
    localparam int PASS_W   = $clog2(PASS_CAP + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_ACC_D  = 3'd3;
    localparam logic [2:0] S_ACC_X  = 3'd4;
    localparam logic [2:0] S_HALF_U = 3'd5;
    localparam logic [2:0] S_HALF_V = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              out_valid_reg, out_valid_next;
    logic [WIDTH:0]    u_reg, u_next;
    logic [WIDTH-1:0]  v_reg, v_next;
    logic [WIDTH-1:0]  x_reg, x_next;
    logic [WIDTH-1:0]  d_reg, d_next;
    logic [WIDTH-1:0]  b_reg, b_next;
    logic              fail_reg, fail_next;
    logic [WIDTH-1:0]  inv_reg, inv_next;
    logic              noinv_reg, noinv_next;

    op_t               alu_op;
    logic [WIDTH:0]    alu_a;
    logic [WIDTH:0]    alu_b;
    logic [WIDTH:0]    alu_res;
    logic [WIDTH-1:0]  a_in;
    logic [WIDTH-1:0]  b_in;
    logic              u_gt_v;
    logic              loop_busy;
    logic              result_load;

    bmi_alu #(
        .WIDTH (WIDTH)
    ) u_alu (
        .op  (alu_op),
        .opa (alu_a),
        .opb (alu_b),
        .m   (b_reg),
        .res (alu_res)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.inverse    = FIELD_W'(inv_reg);
    assign rsp.no_inverse = noinv_reg;

    assign a_in   = req.value[WIDTH-1:0];
    assign b_in   = req.modulus[WIDTH-1:0];
    assign u_gt_v = (u_reg > {1'b0, v_reg});

    // Loop states, and the hand-off of a finished result
    assign loop_busy   = (state_reg == S_CMP) || (state_reg == S_ACC_D)
                         || (state_reg == S_ACC_X) || (state_reg == S_HALF_U)
                         || (state_reg == S_HALF_V);
    assign result_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        x_next         = x_reg;
        d_next         = d_reg;
        b_next         = b_reg;
        fail_next      = fail_reg;
        inv_next       = inv_reg;
        noinv_next     = noinv_reg;
        alu_op         = OP_ADD;
        alu_a          = u_reg;
        alu_b          = {1'b0, b_reg};

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    u_next    = {1'b0, a_in};
                    v_next    = b_in;
                    b_next    = b_in;
                    x_next    = '0;
                    // b is odd on the working path, so b - 1 just clears bit 0
                    d_next    = {b_in[WIDTH-1:1], 1'b0};
                    pass_next = '0;
                    fail_next = 1'b0;
                    if (b_in == {{(WIDTH-1){1'b0}}, 1'b1})
                    begin
                        x_next     = {{(WIDTH-1){1'b0}}, 1'b1};
                        state_next = S_DONE;
                    end
                    else if (!b_in[0])
                    begin
                        fail_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_INIT;
                    end
                end
            end

            // even value: start from value + modulus
            S_INIT:
            begin
                alu_op = OP_ADD;
                alu_a  = u_reg;
                alu_b  = {1'b0, b_reg};
                if (!u_reg[0])
                begin
                    u_next = alu_res;
                end
                state_next = S_CMP;
            end

            // loop head: cap, success test, then subtract smaller from larger
            S_CMP:
            begin
                if (pass_reg == PASS_W'(PASS_CAP))
                begin
                    fail_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (v_reg == {{(WIDTH-1){1'b0}}, 1'b1})
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pass_next = pass_reg + 1'b1;
                    alu_op    = OP_SUB;
                    if (u_gt_v)
                    begin
                        alu_a      = u_reg;
                        alu_b      = {1'b0, v_reg};
                        u_next     = alu_res;
                        state_next = S_ACC_D;
                    end
                    else
                    begin
                        alu_a      = {1'b0, v_reg};
                        alu_b      = u_reg;
                        v_next     = alu_res[WIDTH-1:0];
                        state_next = S_ACC_X;
                    end
                end
            end

            S_ACC_D:
            begin
                alu_op     = OP_ADDM;
                alu_a      = {1'b0, d_reg};
                alu_b      = {1'b0, x_reg};
                d_next     = alu_res[WIDTH-1:0];
                state_next = u_reg[0] ? S_CMP : S_HALF_U;
            end

            S_ACC_X:
            begin
                alu_op = OP_ADDM;
                alu_a  = {1'b0, x_reg};
                alu_b  = {1'b0, d_reg};
                x_next = alu_res[WIDTH-1:0];
                if (v_reg == '0)
                begin
                    fail_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = v_reg[0] ? S_CMP : S_HALF_V;
                end
            end

            // one halving per cycle; u stays nonzero
            S_HALF_U:
            begin
                alu_op     = OP_HALFM;
                alu_a      = {1'b0, d_reg};
                d_next     = alu_res[WIDTH-1:0];
                u_next     = {1'b0, u_reg[WIDTH:1]};
                state_next = u_reg[1] ? S_CMP : S_HALF_U;
            end

            S_HALF_V:
            begin
                alu_op     = OP_HALFM;
                alu_a      = {1'b0, x_reg};
                x_next     = alu_res[WIDTH-1:0];
                v_next     = {1'b0, v_reg[WIDTH-1:1]};
                state_next = v_reg[1] ? S_CMP : S_HALF_V;
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (result_load)
                begin
                    out_valid_next = 1'b1;
                    inv_next       = fail_reg ? '0 : x_reg;
                    noinv_next     = fail_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        v_reg     <= v_next;
        x_reg     <= x_next;
        d_reg     <= d_next;
        b_reg     <= b_next;
        fail_reg  <= fail_next;
        inv_reg   <= inv_next;
        noinv_reg <= noinv_next;
    end

    // Checks
    `BMI_ASSERT_IMP(a_pass_cap, 1'b1, pass_reg <= PASS_W'(PASS_CAP))
    `BMI_ASSERT_IMP(a_v_bound, state_reg != S_IDLE, v_reg <= b_reg)
    `BMI_ASSERT_IMP(a_acc_reduced, loop_busy, x_reg < b_reg && d_reg < b_reg)
    `BMI_ASSERT_NXT(a_done_out, result_load, rsp.valid && state_reg == S_IDLE)

endmodule
